// ===== design/hpgc_pkg.sv =====
package hpgc_pkg;

    // request opcodes; codes six and seven are ignored
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_PAUSE     = 3'd3,
        OP_RESUME    = 3'd4,
        OP_SET_WIDTH = 3'd5
    } op_t;

    // controller modes
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RUN     = 2'd1,
        MODE_PAUSING = 2'd2,
        MODE_GAP     = 2'd3
    } mode_t;

    // command codes captured in the error record
    localparam logic [1:0] ERR_CMD_START  = 2'd0;
    localparam logic [1:0] ERR_CMD_PAUSE  = 2'd1;
    localparam logic [1:0] ERR_CMD_RESUME = 2'd2;

    typedef struct packed {
        op_t         opcode;
        logic        direction;
        logic [15:0] width_value;
    } in_t;

    typedef struct packed {
        logic        forward_pin;
        logic        reverse_pin;
        mode_t       mode;
        logic        pulse_end;
        logic        error_seen;
        mode_t       error_mode;
        logic [1:0]  error_command;
    } out_t;

endpackage

// ===== design/hbridge_pwm_gap_controller_top.sv =====
// result: a request's result is registered and shown in the cycle after acceptance
// throughput: one request per cycle unless a result is stalled; the state update
// and result share a single registered pass, so ticks keep the pwm period exact
// reset: aresetn low (synchronous) returns to idle, both pins low, widths,
// counter and error record cleared, no result pending
module hbridge_pwm_gap_controller_top
    import hpgc_pkg::*;
#(
    parameter int WIDTH_BITS = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam logic [15:0] WIDTH_MAX = 16'((1 << WIDTH_BITS) - 1);
    localparam logic [WIDTH_BITS-1:0] COUNT_LAST = {WIDTH_BITS{1'b1}};

    mode_t                 mode_reg, mode_next;
    logic                  dir_reg, dir_next;
    logic [WIDTH_BITS-1:0] count_reg, count_next;
    logic [WIDTH_BITS-1:0] pend_reg, pend_next;
    logic [WIDTH_BITS-1:0] active_reg, active_next;
    logic [1:0]            pins_reg, pins_next;
    logic                  err_reg, err_next;
    mode_t                 err_mode_reg, err_mode_next;
    logic [1:0]            err_cmd_reg, err_cmd_next;
    logic                  ended;
    logic                  valid_reg;
    out_t                  out_reg;
    logic                  accept;

    // pwm tick helpers
    logic                  ticking;
    logic                  period_wrap;
    logic [WIDTH_BITS-1:0] active_eff;
    logic                  level;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = valid_reg;
    assign m_data  = out_reg;

    assign ticking     = (mode_reg == MODE_RUN) || (mode_reg == MODE_PAUSING);
    assign period_wrap = (count_reg == COUNT_LAST);
    assign active_eff  = (count_reg == '0) ? pend_reg : active_reg;
    assign level       = !(count_reg < active_eff);

    // next mode
    always_comb begin
        mode_next = mode_reg;
        case (s_data.opcode)
            OP_TICK: begin
                if (mode_reg == MODE_PAUSING && period_wrap) begin
                    mode_next = MODE_GAP;
                end
            end
            OP_START: begin
                if (mode_reg == MODE_IDLE) begin
                    mode_next = MODE_RUN;
                end
            end
            OP_STOP: begin
                mode_next = MODE_IDLE;
            end
            OP_PAUSE: begin
                if (mode_reg == MODE_RUN) begin
                    mode_next = MODE_PAUSING;
                end
            end
            OP_RESUME: begin
                if (mode_reg == MODE_GAP) begin
                    mode_next = MODE_RUN;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    // datapath and error record
    always_comb begin
        dir_next      = dir_reg;
        count_next    = count_reg;
        pend_next     = pend_reg;
        active_next   = active_reg;
        pins_next     = pins_reg;
        err_next      = err_reg;
        err_mode_next = err_mode_reg;
        err_cmd_next  = err_cmd_reg;
        ended         = 1'b0;
        case (s_data.opcode)
            OP_TICK: begin
                if (ticking) begin
                    active_next = active_eff;
                    count_next  = count_reg + 1'b1;
                    pins_next   = dir_reg ? {level, 1'b1} : {1'b1, level};
                    if (mode_reg == MODE_PAUSING && period_wrap) begin
                        pins_next = 2'b00;
                        ended     = 1'b1;
                    end
                end
            end
            OP_START: begin
                if (mode_reg == MODE_IDLE) begin
                    pend_next   = '0;
                    active_next = '0;
                    dir_next    = s_data.direction;
                    pins_next   = 2'b11;
                    count_next  = '0;
                end else begin
                    err_next      = 1'b1;
                    err_mode_next = mode_reg;
                    err_cmd_next  = ERR_CMD_START;
                end
            end
            OP_STOP: begin
                pins_next  = 2'b00;
                count_next = '0;
            end
            OP_PAUSE: begin
                if (mode_reg != MODE_RUN) begin
                    err_next      = 1'b1;
                    err_mode_next = mode_reg;
                    err_cmd_next  = ERR_CMD_PAUSE;
                end
            end
            OP_RESUME: begin
                if (mode_reg == MODE_GAP) begin
                    pins_next  = 2'b11;
                    count_next = '0;
                end else begin
                    err_next      = 1'b1;
                    err_mode_next = mode_reg;
                    err_cmd_next  = ERR_CMD_RESUME;
                end
            end
            OP_SET_WIDTH: begin
                if (s_data.width_value > WIDTH_MAX) begin
                    pend_next = COUNT_LAST;
                end else begin
                    pend_next = s_data.width_value[WIDTH_BITS-1:0];
                end
            end
            default: begin
                ended = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            dir_reg      <= 1'b0;
            count_reg    <= '0;
            pend_reg     <= '0;
            active_reg   <= '0;
            pins_reg     <= 2'b00;
            err_reg      <= 1'b0;
            err_mode_reg <= MODE_IDLE;
            err_cmd_reg  <= ERR_CMD_START;
        end else if (accept) begin
            mode_reg     <= mode_next;
            dir_reg      <= dir_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            active_reg   <= active_next;
            pins_reg     <= pins_next;
            err_reg      <= err_next;
            err_mode_reg <= err_mode_next;
            err_cmd_reg  <= err_cmd_next;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg.forward_pin   <= pins_next[0];
            out_reg.reverse_pin   <= pins_next[1];
            out_reg.mode          <= mode_next;
            out_reg.pulse_end     <= ended;
            out_reg.error_seen    <= err_next;
            out_reg.error_mode    <= err_mode_next;
            out_reg.error_command <= err_cmd_next;
        end
    end

endmodule

// ===== design/hpgc_checker.sv =====
module hpgc_assertions
    import hpgc_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // a pending result stays offered
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped before acceptance");

    // a stalled result keeps its payload
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("stalled result payload changed");

    // a completed pause lands in the gap with both pins low
    a_pulse_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.pulse_end |->
            m_data.mode == MODE_GAP && !m_data.forward_pin && !m_data.reverse_pin)
        else $error("pulse end without fast-decay gap");

    // idle and gap hold both pins low
    a_quiet_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.mode == MODE_IDLE || m_data.mode == MODE_GAP) |->
            !m_data.forward_pin && !m_data.reverse_pin)
        else $error("pin high while idle or in gap");

    // running or pausing keeps at least one pin high
    a_drive_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.mode == MODE_RUN || m_data.mode == MODE_PAUSING) |->
            m_data.forward_pin || m_data.reverse_pin)
        else $error("both pins low while driving");

endmodule

bind hbridge_pwm_gap_controller_top hpgc_assertions u_hpgc_assertions (.*);

// ===== tb/sv/hpgc_checker.sv =====
module hpgc_checker
    import hpgc_pkg::*;
#(
    parameter int WIDTH_BITS = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   fail_count,
    output int   open_results,
    output int   results_seen,
    output int   gaps_seen,
    output int   bad_cmds_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] WIDTH_MAX = 16'((32'd1 << WIDTH_BITS) - 1);

    // shadow copy of the controller state
    mode_t                 mode_q;
    logic                  dir_q;
    logic [WIDTH_BITS-1:0] count_q;
    logic [WIDTH_BITS-1:0] pend_w;
    logic [WIDTH_BITS-1:0] act_w;
    logic [1:0]            pins_q;     // bit0 forward, bit1 reverse
    logic                  err_seen_q;
    mode_t                 err_mode_q;
    logic [1:0]            err_cmd_q;

    // bridge status predicted for each accepted request, oldest first
    out_t bridge_status_q[$];

    int fails;
    int results;
    int gaps;
    int bad_cmds;

    // illegal command: only the error record changes
    function automatic void note_bad_cmd(input logic [1:0] cmd);
        err_seen_q = 1'b1;
        err_mode_q = mode_q;
        err_cmd_q  = cmd;
        bad_cmds++;
    endfunction

    // apply one request to the shadow state, return the status it leaves
    function automatic out_t advance_bridge(input in_t req);
        logic lvl;
        logic ended;
        out_t res;
        ended = 1'b0;
        case (req.opcode)
            OP_TICK: begin
                if (mode_q == MODE_RUN || mode_q == MODE_PAUSING) begin
                    // new width only loads at the period start
                    if (count_q == '0)
                        act_w = pend_w;
                    lvl = (count_q < act_w) ? 1'b0 : 1'b1;
                    pins_q = dir_q ? {lvl, 1'b1} : {1'b1, lvl};
                    count_q = count_q + 1'b1;
                    // pause completes when the period wraps
                    if (mode_q == MODE_PAUSING && count_q == '0) begin
                        pins_q = 2'b00;
                        mode_q = MODE_GAP;
                        ended  = 1'b1;
                        gaps++;
                    end
                end
            end
            OP_START: begin
                if (mode_q == MODE_IDLE) begin
                    pend_w  = '0;
                    act_w   = '0;
                    dir_q   = req.direction;
                    pins_q  = 2'b11;
                    count_q = '0;
                    mode_q  = MODE_RUN;
                end else begin
                    note_bad_cmd(ERR_CMD_START);
                end
            end
            OP_STOP: begin
                pins_q  = 2'b00;
                count_q = '0;
                mode_q  = MODE_IDLE;
            end
            OP_PAUSE: begin
                if (mode_q == MODE_RUN)
                    mode_q = MODE_PAUSING;
                else
                    note_bad_cmd(ERR_CMD_PAUSE);
            end
            OP_RESUME: begin
                if (mode_q == MODE_GAP) begin
                    pins_q  = 2'b11;
                    count_q = '0;
                    mode_q  = MODE_RUN;
                end else begin
                    note_bad_cmd(ERR_CMD_RESUME);
                end
            end
            OP_SET_WIDTH: begin
                pend_w = (req.width_value > WIDTH_MAX) ? WIDTH_MAX[WIDTH_BITS-1:0]
                                                       : req.width_value[WIDTH_BITS-1:0];
            end
            default: begin
            end
        endcase
        res.forward_pin   = pins_q[0];
        res.reverse_pin   = pins_q[1];
        res.mode          = mode_q;
        res.pulse_end     = ended;
        res.error_seen    = err_seen_q;
        res.error_mode    = err_mode_q;
        res.error_command = err_cmd_q;
        return res;
    endfunction

    function automatic int field_bad(input string name, input logic [1:0] want,
                                     input logic [1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // compare results first, then record the new request
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            mode_q     = MODE_IDLE;
            dir_q      = 1'b0;
            count_q    = '0;
            pend_w     = '0;
            act_w      = '0;
            pins_q     = 2'b00;
            err_seen_q = 1'b0;
            err_mode_q = MODE_IDLE;
            err_cmd_q  = ERR_CMD_START;
            bridge_status_q.delete();
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                results++;
                if (bridge_status_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, m_data);
                    fails++;
                end else begin
                    want = bridge_status_q.pop_front();
                    fails += field_bad("forward_pin", want.forward_pin, m_data.forward_pin);
                    fails += field_bad("reverse_pin", want.reverse_pin, m_data.reverse_pin);
                    fails += field_bad("mode", want.mode, m_data.mode);
                    fails += field_bad("pulse_end", want.pulse_end, m_data.pulse_end);
                    fails += field_bad("error_seen", want.error_seen, m_data.error_seen);
                    fails += field_bad("error_mode", want.error_mode, m_data.error_mode);
                    fails += field_bad("error_command", want.error_command,
                                       m_data.error_command);
                end
            end
            if (s_valid && s_ready)
                bridge_status_q.push_back(advance_bridge(s_data));
        end
        fail_count    <= fails;
        open_results  <= bridge_status_q.size();
        results_seen  <= results;
        gaps_seen     <= gaps;
        bad_cmds_seen <= bad_cmds;
    end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import hpgc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 750;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 80;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    int fail_count;
    int open_results;
    int results_seen;
    int gaps_seen;
    int bad_cmds_seen;

    int sent_total    = 0;
    int ignored_total = 0;
    int counted_total = 0;
    int burst_left    = 0;
    int cycle_cnt     = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    hbridge_pwm_gap_controller_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hpgc_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .open_results  (open_results),
        .results_seen  (results_seen),
        .gaps_seen     (gaps_seen),
        .bad_cmds_seen (bad_cmds_seen)
    );

    // request with random contents in the fields the opcode ignores
    function automatic in_t make_req(input op_t op);
        in_t r;
        r.opcode      = op;
        r.direction   = 1'($urandom_range(0, 1));
        r.width_value = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    function automatic in_t noise_req();
        in_t r;
        r = make_req(OP_TICK);
        r.opcode = op_t'(3'($urandom_range(0, 7)));
        return r;
    endfunction

    // widths biased toward the edges and the saturating range
    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 9))
            0, 1:    return 16'd0;
            2:       return 16'd255;
            3, 4:    return 16'($urandom_range(256, 65535));
            default: return 16'($urandom_range(1, 254));
        endcase
    endfunction

    // offer one request, bursts separated by random gaps
    task automatic send_req(input in_t req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_total++;
        if (req.opcode > OP_SET_WIDTH)
            ignored_total++;
        else
            counted_total++;
    endtask

    task automatic send_width(input logic [15:0] w);
        in_t r;
        r = make_req(OP_SET_WIDTH);
        r.width_value = w;
        send_req(r);
    endtask

    // run of ticks with an occasional stray request mixed in
    task automatic send_ticks(input int n);
        for (int i = 0; i < n && sent_total < ITEM_TARGET; i++) begin
            if ($urandom_range(0, 99) < 2)
                send_req(noise_req());
            else
                send_req(make_req(OP_TICK));
        end
    endtask

    // start, run, optionally pause toward the gap and resume, stop
    task automatic run_session();
        send_req(make_req(OP_START));
        send_width(pick_width());
        send_ticks(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120));
        if ($urandom_range(0, 3) == 0)
            send_width(pick_width());
        send_ticks(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 200));
        if ($urandom_range(0, 4) != 0) begin
            send_req(make_req(OP_PAUSE));
            if ($urandom_range(0, 3) == 0)
                send_req(make_req(OP_PAUSE));
            send_ticks($urandom_range(150, 280));
            if ($urandom_range(0, 2) == 0)
                send_req(make_req(($urandom_range(0, 1) == 0) ? OP_START : OP_PAUSE));
            if ($urandom_range(0, 4) != 0) begin
                send_req(make_req(OP_RESUME));
                send_ticks($urandom_range(1, 150));
            end
        end else if ($urandom_range(0, 1) == 0) begin
            send_req(make_req(OP_RESUME));
        end
        send_req(make_req(OP_STOP));
        if ($urandom_range(0, 2) == 0)
            send_req(noise_req());
    endtask

    // receiver: changing ready patterns plus one long hold-off
    initial begin
        int ready_pct;
        int phase_left;
        bit hold_done;
        ready_pct  = 100;
        phase_left = 0;
        hold_done  = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && sent_total >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                if (phase_left == 0) begin
                    case ($urandom_range(0, 2))
                        0:       ready_pct = 100;
                        1:       ready_pct = 70;
                        default: ready_pct = 30;
                    endcase
                    phase_left = $urandom_range(16, 96);
                end
                phase_left--;
                m_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        in_t r;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // tick, illegal commands and stop while idle
        send_req(make_req(OP_TICK));
        send_req(make_req(OP_PAUSE));
        send_req(make_req(OP_RESUME));
        send_req(make_req(OP_STOP));
        // forward run, saturated width, errors while running and pausing
        r = make_req(OP_START);
        r.direction = 1'b0;
        send_req(r);
        r.direction = 1'b1;
        send_req(r);
        send_req(make_req(OP_RESUME));
        send_width(16'hFFFF);
        send_req(make_req(OP_TICK));
        send_req(make_req(OP_TICK));
        send_width(16'd0);
        send_req(make_req(OP_PAUSE));
        send_req(make_req(OP_PAUSE));
        send_req(make_req(OP_START));
        send_req(make_req(OP_RESUME));
        send_req(make_req(OP_STOP));
        // reverse run, pause right at the period boundary
        r = make_req(OP_START);
        r.direction = 1'b1;
        send_req(r);
        send_width(16'd256);
        send_req(make_req(OP_PAUSE));
        send_req(make_req(OP_TICK));
        // unused opcodes
        r = make_req(OP_TICK);
        r.opcode = op_t'(3'd6);
        send_req(r);
        r.opcode = op_t'(3'd7);
        send_req(r);
        send_req(make_req(OP_STOP));
        send_width(16'd0);

        // random sessions with some noise between them
        while (sent_total < ITEM_TARGET) begin
            run_session();
            if ($urandom_range(0, 3) == 0)
                send_ticks($urandom_range(1, 6));
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (open_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("covered %0d requests (%0d with unused opcodes), %0d results compared",
                 sent_total, ignored_total, results_seen);
        $display("reached the fast-decay gap %0d times, %0d illegal commands recorded",
                 gaps_seen, bad_cmds_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
